// ===== rtl/bnt_pkg.sv =====
// Shared types and character codes for the bracket nesting tracker.
`default_nettype none

package bnt_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CH_HASH    = 21'h00023;
    localparam logic [CP_W-1:0] CH_LROUND  = 21'h00028;
    localparam logic [CP_W-1:0] CH_RROUND  = 21'h00029;
    localparam logic [CP_W-1:0] CH_LSQUARE = 21'h0005B;
    localparam logic [CP_W-1:0] CH_RSQUARE = 21'h0005D;
    localparam logic [CP_W-1:0] CH_DQUOTE  = 21'h00022;
    localparam logic [CP_W-1:0] CH_SQUOTE  = 21'h00027;
    localparam logic [CP_W-1:0] CH_BSLASH  = 21'h0005C;

    // Stored closer kind, one bit per stack entry.
    localparam logic KIND_ROUND  = 1'b0;
    localparam logic KIND_SQUARE = 1'b1;

    // Quote that opened the current string.
    localparam logic QUOTE_DOUBLE = 1'b0;
    localparam logic QUOTE_SINGLE = 1'b1;

    // Reported closer on top of the stack.
    localparam logic [1:0] CLOSER_NONE   = 2'd0;
    localparam logic [1:0] CLOSER_ROUND  = 2'd1;
    localparam logic [1:0] CLOSER_SQUARE = 2'd2;

    localparam logic [5:0] OPEN_COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_COMMENT = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } stack_op_t;

    typedef struct packed {
        stack_op_t op;
        logic      kind;
    } stack_ctl_t;

    typedef struct packed {
        logic       overflowed;
        logic       inside_string;
        logic [1:0] expected_closer;
        logic [5:0] open_count;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/bracket_nesting_tracker.sv =====
// Top level of the bracket nesting tracker: scanner, stack cell chain, output skid.
//
// Usage:
//   Input channel (s_): one code point per request in s_tdata[20:0], s_tlast marks
//   the last character of a line, s_tuser restarts (empties) the bracket stack
//   before the character is handled.
//   Result channel (m_): one result per input request, in order: open bracket
//   count, closer expected on top, string-open flag and sticky overflow flag.
//   Each result is registered in the main result register, or in the skid register.
//   Throughput: one request per cycle while s_tready is high. The stack is a row of
//   STACK_DEPTH shift cells; push and pop move every cell in the same cycle,
//   and the scanner sees only the top two cells, so no step waits on a memory.
//   Stall: a two-entry output buffer (result register plus skid register) sits
//   on the m_ side; s_tready depends only on the skid register, so one more
//   request is taken while a result waits, and s_tready drops once both hold.
//   Reset (aresetn low, synchronous): stack empty, normal text mode, overflow
//   flag clear, output buffer empty. Cell contents are not cleared; only
//   entries below the count are ever reported.
`default_nettype none

module bracket_nesting_tracker
    import bnt_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic        s_tlast,   // end_of_line
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [5:0] open_count, [7:6] expected_closer,
                                        // [8] inside_string, [9] overflowed, [15:10] zero
);

    logic       in_fire;
    logic       out_fire;
    stack_ctl_t ctl;
    result_t    res;
    logic       cell_kind [STACK_DEPTH];

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Scanner: mode, count and the push/pop request for the cell row.
    bnt_scan #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .code_point  (s_tdata[CP_W-1:0]),
        .end_of_line (s_tlast),
        .restart     (s_tuser),
        .top_kind    (cell_kind[0]),
        .second_kind (cell_kind[1]),
        .ctl         (ctl),
        .res         (res)
    );

    // Cell 0 is the stack top; a push shifts toward higher cells, a pop back.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic above;
        logic below;
        if (i == 0) begin : g_first
            assign above = ctl.kind;
        end else begin : g_mid_above
            assign above = cell_kind[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign below = KIND_ROUND;
        end else begin : g_mid_below
            assign below = cell_kind[i+1];
        end
        bnt_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .above_kind (above),
            .below_kind (below),
            .kind       (cell_kind[i])
        );
    end

    // Output buffer: main result register and a skid register behind it.
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire) begin
            if (skid_valid_reg) begin
                // in_fire cannot happen here: s_tready is low
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_fire;
                main_data_next  = res;
            end
        end else if (in_fire) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {6'b0, main_data_reg};

    // The skid register is only filled behind a waiting main result.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a result while main register is empty");

    // A string never stays open past the end of a line.
    a_eol_closes_string: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |-> !res.inside_string)
        else $error("string still open at end of line");

    // An empty stack reports no closer, a non-empty one always reports one.
    a_closer_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> ((res.open_count == 6'd0) == (res.expected_closer == CLOSER_NONE)))
        else $error("expected closer inconsistent with open count");

    // Once set, the overflow flag stays set on every later request.
    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res.overflowed) |=> (in_fire |-> res.overflowed))
        else $error("overflow flag cleared");

endmodule

`default_nettype wire

// ===== rtl/bnt_cell.sv =====
// One stack cell: holds a closer kind and shifts with its neighbors.
`default_nettype none

module bnt_cell
    import bnt_pkg::*;
(
    input  wire logic       aclk,
    input  wire stack_ctl_t ctl,
    input  wire logic       above_kind,
    input  wire logic       below_kind,
    output logic            kind
);

    logic kind_reg;
    logic kind_next;

    always_comb begin
        kind_next = kind_reg;
        unique case (ctl.op)
            OP_PUSH: kind_next = above_kind;
            OP_POP:  kind_next = below_kind;
            default: kind_next = kind_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

`default_nettype wire

// ===== rtl/bnt_scan.sv =====
// Character scanner: string/comment tracking, stack depth and stack control.
`default_nettype none

module bnt_scan
    import bnt_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_fire,
    input  wire logic [CP_W-1:0] code_point,
    input  wire logic            end_of_line,
    input  wire logic            restart,
    input  wire logic            top_kind,
    input  wire logic            second_kind,
    output stack_ctl_t           ctl,
    output result_t              res
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    scan_mode_t       mode_reg, mode_next;
    logic             quote_reg, quote_next;
    logic             bslash_reg, bslash_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [CNT_W-1:0] cnt_eff;
    logic [CP_W-1:0]  quote_ch;
    stack_ctl_t       op_req;
    logic             new_top;
    logic [31:0]      cnt_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            quote_reg  <= QUOTE_DOUBLE;
            bslash_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= '0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            quote_reg  <= quote_next;
            bslash_reg <= bslash_next;
            ovf_reg    <= ovf_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        quote_next  = quote_reg;
        bslash_next = bslash_reg;
        ovf_next    = ovf_reg;
        op_req.op   = OP_HOLD;
        op_req.kind = KIND_ROUND;
        cnt_eff     = restart ? '0 : cnt_reg;
        quote_ch    = (quote_reg == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

        unique case (mode_reg)
            MODE_STRING: begin
                if (code_point == quote_ch) begin
                    if (bslash_reg) begin
                        bslash_next = 1'b0;
                    end else begin
                        mode_next = MODE_NORMAL;
                    end
                end else begin
                    bslash_next = (code_point == CH_BSLASH);
                end
            end
            MODE_COMMENT: begin
                mode_next = MODE_COMMENT;
            end
            default: begin
                // normal text, and the unused mode code
                mode_next = MODE_NORMAL;
                unique case (code_point)
                    CH_HASH: mode_next = MODE_COMMENT;
                    CH_LROUND, CH_LSQUARE: begin
                        if (cnt_eff < CNT_FULL) begin
                            op_req.op   = OP_PUSH;
                            op_req.kind = (code_point == CH_LSQUARE) ? KIND_SQUARE
                                                                     : KIND_ROUND;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    CH_RROUND, CH_RSQUARE: begin
                        if (cnt_eff != '0 &&
                            top_kind == (code_point == CH_RSQUARE)) begin
                            op_req.op = OP_POP;
                        end
                    end
                    CH_DQUOTE: begin
                        mode_next   = MODE_STRING;
                        quote_next  = QUOTE_DOUBLE;
                        bslash_next = 1'b0;
                    end
                    CH_SQUOTE: begin
                        mode_next   = MODE_STRING;
                        quote_next  = QUOTE_SINGLE;
                        bslash_next = 1'b0;
                    end
                    default: mode_next = MODE_NORMAL;
                endcase
            end
        endcase

        if (end_of_line) begin
            mode_next   = MODE_NORMAL;
            bslash_next = 1'b0;
        end

        unique case (op_req.op)
            OP_PUSH: cnt_next = cnt_eff + 1'b1;
            OP_POP:  cnt_next = cnt_eff - 1'b1;
            default: cnt_next = cnt_eff;
        endcase
    end

    // Stack moves only on an accepted request.
    always_comb begin
        ctl      = op_req;
        if (!in_fire) begin
            ctl.op = OP_HOLD;
        end
    end

    // Top kind after this request's stack move.
    always_comb begin
        unique case (op_req.op)
            OP_PUSH: new_top = op_req.kind;
            OP_POP:  new_top = second_kind;
            default: new_top = top_kind;
        endcase
    end

    assign cnt_wide            = 32'(cnt_next);
    assign res.open_count      = (cnt_wide > 32'(OPEN_COUNT_MAX)) ? OPEN_COUNT_MAX
                                                                  : cnt_wide[5:0];
    assign res.expected_closer = (cnt_next == '0) ? CLOSER_NONE :
                                 (new_top == KIND_SQUARE) ? CLOSER_SQUARE : CLOSER_ROUND;
    assign res.inside_string   = (mode_next == MODE_STRING);
    assign res.overflowed      = ovf_next;

endmodule

`default_nettype wire

// ===== dv/bnt_nesting_checker.sv =====
// Request/result monitor, bracket nesting predictor and result comparison.
`timescale 1ns / 100ps

module bnt_nesting_checker
    import bnt_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,     // [20:0] code_point, [23:21] zero
    input  wire logic        s_tlast,     // end_of_line
    input  wire logic        s_tuser,     // restart
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,     // [5:0] open_count, [7:6] expected_closer,
                                          // [8] inside_string, [9] overflowed, [15:10] zero
    input  wire logic        end_of_test,
    output int               mismatch_count,
    output int               outstanding,
    output int               results_checked
);

    // Predictor state
    logic [STACK_DEPTH-1:0] closer_kinds;
    int                     open_depth;
    scan_mode_t             mode;
    logic                   quote;
    logic                   escape_pending;
    logic                   overflow_seen;

    result_t owed_results[$];
    logic    leftovers_reported;

    // Advances the scanner by one character and returns the result it reports.
    function automatic result_t scan_char(input logic [CP_W-1:0] cp, input logic eol,
                                          input logic rst);
        result_t         r;
        logic [CP_W-1:0] open_quote;
        if (rst)
            open_depth = 0;
        case (mode)
            MODE_STRING: begin
                open_quote = (quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (cp == open_quote) begin
                    if (escape_pending)
                        escape_pending = 1'b0;
                    else
                        mode = MODE_NORMAL;
                end else begin
                    escape_pending = (cp == CH_BSLASH);
                end
            end
            MODE_COMMENT: ;
            default: begin
                mode = MODE_NORMAL;
                case (cp)
                    CH_HASH: mode = MODE_COMMENT;
                    CH_LROUND, CH_LSQUARE: begin
                        if (open_depth >= STACK_DEPTH) begin
                            overflow_seen = 1'b1;
                        end else begin
                            closer_kinds[open_depth] = (cp == CH_LSQUARE) ? KIND_SQUARE
                                                                          : KIND_ROUND;
                            open_depth++;
                        end
                    end
                    CH_RROUND, CH_RSQUARE: begin
                        if (open_depth > 0 && closer_kinds[open_depth-1] ==
                            ((cp == CH_RSQUARE) ? KIND_SQUARE : KIND_ROUND))
                            open_depth--;
                    end
                    CH_DQUOTE, CH_SQUOTE: begin
                        mode           = MODE_STRING;
                        quote          = (cp == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                        escape_pending = 1'b0;
                    end
                    default: ;
                endcase
            end
        endcase
        if (eol) begin
            mode           = MODE_NORMAL;
            escape_pending = 1'b0;
        end
        r.open_count      = (open_depth > 63) ? OPEN_COUNT_MAX : 6'(open_depth);
        r.expected_closer = (open_depth == 0) ? CLOSER_NONE :
                            (closer_kinds[open_depth-1] == KIND_SQUARE) ? CLOSER_SQUARE
                                                                        : CLOSER_ROUND;
        r.inside_string   = (mode == MODE_STRING);
        r.overflowed      = overflow_seen;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            open_depth         = 0;
            mode               = MODE_NORMAL;
            quote              = QUOTE_DOUBLE;
            escape_pending     = 1'b0;
            overflow_seen      = 1'b0;
            owed_results.delete();
            mismatch_count     = 0;
            results_checked    = 0;
            leftovers_reported = 1'b0;
        end else begin
            // Result first: it can only belong to a request from an earlier edge.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[9:0]);
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result %h, nothing owed", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    results_checked++;
                    if (got.open_count !== want.open_count) begin
                        $display("%0t: open_count expected %0d actual %0d",
                                 $time, want.open_count, got.open_count);
                        mismatch_count++;
                    end
                    if (got.expected_closer !== want.expected_closer) begin
                        $display("%0t: expected_closer expected %0d actual %0d",
                                 $time, want.expected_closer, got.expected_closer);
                        mismatch_count++;
                    end
                    if (got.inside_string !== want.inside_string) begin
                        $display("%0t: inside_string expected %0b actual %0b",
                                 $time, want.inside_string, got.inside_string);
                        mismatch_count++;
                    end
                    if (got.overflowed !== want.overflowed) begin
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $time, want.overflowed, got.overflowed);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(scan_char(s_tdata[CP_W-1:0], s_tlast, s_tuser));
            if (end_of_test && !leftovers_reported) begin
                leftovers_reported = 1'b1;
                if (owed_results.size() != 0) begin
                    $display("%0t: %0d results never arrived", $time, owed_results.size());
                    mismatch_count += owed_results.size();
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

// ===== dv/bracket_nesting_tracker_tb.sv =====
// Testbench top for the bracket nesting tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module bracket_nesting_tracker_tb;
    import bnt_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int RANDOM_CHARS = 1450;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [23:0] s_tdata     = '0;     // [20:0] code_point, [23:21] zero
    logic        s_tlast     = 1'b0;   // end_of_line
    logic        s_tuser     = 1'b0;   // restart
    logic        m_tready    = 1'b0;
    logic        end_of_test = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;              // [5:0] open_count, [7:6] expected_closer,
                                       // [8] inside_string, [9] overflowed, [15:10] zero

    int mismatch_count;
    int outstanding;
    int results_checked;

    // Stimulus bookkeeping
    int   chars_sent    = 0;
    int   lines_sent    = 0;
    int   restarts_sent = 0;
    int   burst_left    = 0;
    // Rough copy of the open brackets, used only to pick matching closers.
    // It ignores strings and comments, so it drifts now and then; that is fine.
    logic open_kinds[$];

    // Receiver stall pattern
    int stall_style = 0;
    int stall_timer = 0;
    int stall_phase = 0;

    bracket_nesting_tracker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bnt_nesting_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .end_of_test     (end_of_test),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #10 aclk = ~aclk;

    // Receiver: now and then pick a new stall style at random. Style 0 never
    // stalls, so long stretches run at full rate; style 2 stalls hard enough
    // to fill the output skid and push back on s_tready.
    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_timer = $urandom_range(16, 96);
        end else begin
            stall_timer--;
        end
        stall_phase++;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_phase[2];
        endcase
    end

    // Sender gap: valid held low; n sets the length of the gap.
    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Drive one character request and wait for the handshake. Inside a burst
    // the next request follows on the very next cycle with valid held high.
    task automatic send_char(input logic [CP_W-1:0] cp, input logic eol, input logic rst);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cp};
        s_tlast  <= eol;
        s_tuser  <= rst;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        chars_sent++;
        if (eol)
            lines_sent++;
        if (rst) begin
            restarts_sent++;
            open_kinds.delete();
        end
        if (cp == CH_LROUND || cp == CH_LSQUARE) begin
            if (open_kinds.size() < STACK_DEPTH)
                open_kinds.push_back((cp == CH_LSQUARE) ? KIND_SQUARE : KIND_ROUND);
        end else if ((cp == CH_RROUND || cp == CH_RSQUARE) && open_kinds.size() > 0 &&
                     open_kinds[$] == ((cp == CH_RSQUARE) ? KIND_SQUARE : KIND_ROUND)) begin
            void'(open_kinds.pop_back());
        end
        if (burst_left == 0) begin
            pause_sender($urandom_range(1, 12));
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    // Hold off new requests until every owed result has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // A source-like line: brackets, mostly matching closers, quotes, escapes,
    // comments, plain text and rare restarts, ending with end_of_line.
    task automatic send_line();
        int              len;
        int              roll;
        logic [CP_W-1:0] cp;
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
                cp = $urandom_range(0, 1) ? CH_LSQUARE : CH_LROUND;
            end else if (roll < 30) begin
                if (open_kinds.size() > 0 && $urandom_range(0, 4) != 0)
                    cp = (open_kinds[$] == KIND_SQUARE) ? CH_RSQUARE : CH_RROUND;
                else
                    cp = $urandom_range(0, 1) ? CH_RSQUARE : CH_RROUND;
            end else if (roll < 39) begin
                cp = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            end else if (roll < 45) begin
                cp = CH_BSLASH;
            end else if (roll < 48) begin
                cp = CH_HASH;
            end else if (roll < 90) begin
                cp = CP_W'($urandom_range(32, 126));
            end else begin
                cp = CP_W'($urandom());
            end
            send_char(cp, i == len - 1, $urandom_range(0, 49) == 0);
        end
    endtask

    // Long run of openers with no end of line: can drive the stack into overflow.
    task automatic send_deep_nest();
        repeat ($urandom_range(28, 36))
            send_char($urandom_range(0, 1) ? CH_LSQUARE : CH_LROUND, 1'b0, 1'b0);
    endtask

    // Short burst of raw requests: any code point, random line end and restart.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_char(CP_W'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int  roll;
        int  random_start;
        logic mid_drained;
        mid_drained = 1'b0;
        burst_left  = $urandom_range(0, 40);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part
        send_char(21'h000000, 1'b0, 1'b0);     // lowest code point
        send_char(CH_RROUND, 1'b0, 1'b0);      // closer on empty stack, ignored
        send_char(CH_LROUND, 1'b0, 1'b0);
        send_char(CH_RSQUARE, 1'b0, 1'b0);     // wrong closer, ignored
        send_char(CH_LSQUARE, 1'b0, 1'b0);
        send_char(CH_RSQUARE, 1'b0, 1'b0);
        send_char(CH_RROUND, 1'b0, 1'b0);      // back to empty
        send_char(CH_DQUOTE, 1'b0, 1'b0);      // double-quoted string opens
        send_char(CH_LROUND, 1'b0, 1'b0);      // bracket inside string, ignored
        send_char(CH_BSLASH, 1'b0, 1'b0);
        send_char(CH_DQUOTE, 1'b0, 1'b0);      // escaped quote, string stays open
        send_char(CH_BSLASH, 1'b0, 1'b0);
        send_char(CH_BSLASH, 1'b0, 1'b0);      // backslash after backslash still marks
        send_char(CH_DQUOTE, 1'b0, 1'b0);      // so this quote is escaped too
        send_char(CH_DQUOTE, 1'b0, 1'b0);      // closes the string
        send_char(CH_SQUOTE, 1'b0, 1'b0);      // single-quoted string
        send_char(CH_DQUOTE, 1'b0, 1'b0);      // other quote kind does not close it
        send_char(21'h000061, 1'b1, 1'b0);     // end of line ends the string
        send_char(CH_HASH, 1'b0, 1'b0);        // comment
        send_char(CH_LROUND, 1'b1, 1'b0);      // ignored in comment, line ends
        send_char(CH_LSQUARE, 1'b0, 1'b0);
        send_char(21'h1FFFFF, 1'b0, 1'b0);     // all-ones code point
        send_char(21'h10FFFF, 1'b0, 1'b0);     // highest valid code point
        send_char(21'h110000, 1'b0, 1'b1);     // beyond Unicode, with restart
        send_char(CH_RSQUARE, 1'b1, 1'b0);     // stack was emptied, ignored

        wait_for_drain();

        // Random part: mostly well-formed lines, some deep nesting and noise
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            if (!mid_drained && chars_sent - random_start >= RANDOM_CHARS / 2) begin
                wait_for_drain();
                mid_drained = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 78)
                send_line();
            else if (roll < 83)
                send_deep_nest();
            else
                send_noise();
        end

        wait_for_drain();
        repeat (4) @(negedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);

        $display("Run covered %0d characters in %0d lines with %0d stack restarts,",
                 chars_sent, lines_sent, restarts_sent);
        $display("under random sender bursts and receiver stalls; %0d results compared.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Timeout at %0t", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
